FILE: src/pending_id_handle_map_assert.svh
// Assertion macros for the pending id / handle map.
// Used by the top level; no other dependencies.
`ifndef PENDING_ID_HANDLE_MAP_ASSERT_SVH
`define PENDING_ID_HANDLE_MAP_ASSERT_SVH

// same-cycle implication
`define PHM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PHM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/phm_pkg.sv
// Shared types and constants for the pending id / handle map.
// No dependencies.
`default_nettype none

package phm_pkg;

   localparam int unsigned PENDING_DEPTH_DEF = 16;
   localparam int unsigned MAP_DEPTH_DEF     = 64;

   typedef enum logic [2:0] {
      CMD_NEXT_ID       = 3'd0,
      CMD_PUSH          = 3'd1,
      CMD_COMPLETE      = 3'd2,
      CMD_REMOVE        = 3'd3,
      CMD_LOOKUP_ID     = 3'd4,
      CMD_LOOKUP_HANDLE = 3'd5,
      CMD_COUNT         = 3'd6
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_PEND_FULL  = 3'd1,
      ST_PEND_EMPTY = 3'd2,
      ST_NOT_FOUND  = 3'd3,
      ST_MAP_FULL   = 3'd4
   } status_type;

   // flags from the shared compare unit
   typedef struct packed {
      logic key_eq;
      logic id_eq;
      logic id_lt;
      logic ord_lt;
   } match_res_type;

endpackage

`default_nettype wire

FILE: src/phm_ifs.sv
// Request and response channel interfaces (valid/ready plus payload).
// No dependencies.
`default_nettype none

interface phm_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [31:0] req_id;
   logic [31:0] handle;

   modport source (output valid, output cmd, output req_id, output handle, input ready);
   modport sink   (input valid, input cmd, input req_id, input handle, output ready);
endinterface

interface phm_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_id;
   logic [31:0] out_handle;
   logic        found;
   logic [4:0]  pending_count;
   logic [2:0]  status;

   modport source (output valid, output out_id, output out_handle, output found,
                   output pending_count, output status, input ready);
   modport sink   (input valid, input out_id, input out_handle, input found,
                   input pending_count, input status, output ready);
endinterface

`default_nettype wire

FILE: src/phm_match_unit.sv
// Shared compare unit: key equality, id ordering and rank ordering.
// Depends on phm_pkg.
`default_nettype none

module phm_match_unit #(
   parameter int unsigned ORDER_W = 6
) (
   input  wire logic [31:0]          key_a,
   input  wire logic [31:0]          key_b,
   input  wire logic [31:0]          id_c,
   input  wire logic [31:0]          id_d,
   input  wire logic [ORDER_W-1:0]   ord_a,
   input  wire logic [ORDER_W-1:0]   ord_b,
   output phm_pkg::match_res_type    res
);
   import phm_pkg::*;

   always_comb begin
      res.key_eq = (key_a == key_b);
      res.id_eq  = (id_c == id_d);
      res.id_lt  = (id_c < id_d);
      res.ord_lt = (ord_a < ord_b);
   end

endmodule

`default_nettype wire

FILE: src/pending_id_handle_map.sv
// Pending id / handle map. One request at a time; ready only when idle.
// Push, count and error cases go straight to the done state; complete walks the map to the
// first free slot; next id scans the pending ids (scan restarts on every id skipped); lookups
// walk the whole map; remove walks the map, then renumbers it. Scans take one entry per cycle.
// Reset (synchronous) clears pointers, counter and valid bits; no clearing pass.
`default_nettype none
`include "pending_id_handle_map_assert.svh"

module pending_id_handle_map #(
   parameter int unsigned PENDING_DEPTH = phm_pkg::PENDING_DEPTH_DEF,
   parameter int unsigned MAP_DEPTH     = phm_pkg::MAP_DEPTH_DEF
) (
   input wire logic clock,
   input wire logic reset,
   phm_req_if.sink   req_bus,
   phm_rsp_if.source rsp_bus
);
   import phm_pkg::*;

   // pointer, fill, map index and map count widths
   localparam int unsigned PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
   localparam int unsigned FW = $clog2(PENDING_DEPTH + 1);
   localparam int unsigned SW = PW + 1;
   localparam int unsigned MI = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
   localparam int unsigned UW = $clog2(MAP_DEPTH + 1);

   localparam logic [PW-1:0] PEND_LAST = PW'(PENDING_DEPTH - 1);
   localparam logic [FW-1:0] PEND_FULL = FW'(PENDING_DEPTH);
   localparam logic [SW-1:0] PEND_SPAN = SW'(PENDING_DEPTH);
   localparam logic [MI-1:0] MAP_LAST  = MI'(MAP_DEPTH - 1);
   localparam logic [UW-1:0] MAP_FULL  = UW'(MAP_DEPTH);

   // sequencer states
   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_PSCAN = 7'b0000010,  // walk pending ring for the candidate id
      S_FREE  = 7'b0000100,  // look for first free map slot
      S_MSCAN = 7'b0001000,  // walk map for best match
      S_RENUM = 7'b0010000,  // close the rank gap after a removal
      S_DONE  = 7'b0100000,  // hand result to output register
      S_SPARE = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // architectural state
   logic [PW-1:0]        head_ff, head_in;
   logic [FW-1:0]        fill_ff, fill_in;
   logic [31:0]          ctr_ff, ctr_in;
   logic [MAP_DEPTH-1:0] valid_ff, valid_in;
   logic [UW-1:0]        used_ff, used_in;

   // per-request working registers
   logic [2:0]           cmd_ff, cmd_in;
   logic [31:0]          key_ff, key_in;
   logic [31:0]          handle_ff, handle_in;
   logic [PW-1:0]        scan_ptr_ff, scan_ptr_in;
   logic [FW-1:0]        scan_k_ff, scan_k_in;
   logic [MI-1:0]        midx_ff, midx_in;
   logic                 best_valid_ff, best_valid_in;
   logic [31:0]          best_id_ff, best_id_in;
   logic [31:0]          best_handle_ff, best_handle_in;
   logic [MI-1:0]        best_order_ff, best_order_in;
   logic [MI-1:0]        best_idx_ff, best_idx_in;

   logic [31:0]          res_id_ff, res_id_in;
   logic [31:0]          res_handle_ff, res_handle_in;
   logic                 res_found_ff, res_found_in;
   status_type           res_status_ff, res_status_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_id_ff, rsp_id_in;
   logic [31:0]          rsp_handle_ff, rsp_handle_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [4:0]           rsp_count_ff, rsp_count_in;
   status_type           rsp_status_ff, rsp_status_in;

   // pending ring memory
   logic [31:0]          pend_mem [PENDING_DEPTH];
   logic [31:0]          pend_rdata_ff;
   logic                 pend_we;
   logic [PW-1:0]        pend_waddr;
   logic [SW-1:0]        tail_sum;

   // map memories
   logic [31:0]          map_id_mem     [MAP_DEPTH];
   logic [31:0]          map_handle_mem [MAP_DEPTH];
   logic [MI-1:0]        map_order_mem  [MAP_DEPTH];
   logic [31:0]          map_rd_id_ff;
   logic [31:0]          map_rd_handle_ff;
   logic [MI-1:0]        map_rd_order_ff;
   logic                 map_we;
   logic [MI-1:0]        map_waddr;
   logic [31:0]          map_wid;
   logic [31:0]          map_whandle;
   logic [MI-1:0]        map_word;

   // shared compare unit operands
   logic [31:0]          cmp_key_a, cmp_key_b;
   logic [MI-1:0]        cmp_ord_a, cmp_ord_b;
   match_res_type        mres;

   // candidate-best merge for the map scan
   logic                 take_now;
   logic                 nb_valid;
   logic [31:0]          nb_id, nb_handle;
   logic [MI-1:0]        nb_order, nb_idx;
   logic [PW-1:0]        head_next, scan_ptr_next;

   assign req_bus.ready         = (state_ff == S_IDLE);
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.out_id        = rsp_id_ff;
   assign rsp_bus.out_handle    = rsp_handle_ff;
   assign rsp_bus.found         = rsp_found_ff;
   assign rsp_bus.pending_count = rsp_count_ff;
   assign rsp_bus.status        = rsp_status_ff;

   // tail = (head + fill) mod depth; sum stays below twice the depth
   assign tail_sum   = SW'(head_ff) + SW'(fill_ff);
   assign pend_waddr = (tail_sum >= PEND_SPAN) ? PW'(tail_sum - PEND_SPAN) : PW'(tail_sum);

   assign head_next     = (head_ff == PEND_LAST) ? '0 : head_ff + PW'(1);
   assign scan_ptr_next = (scan_ptr_ff == PEND_LAST) ? '0 : scan_ptr_ff + PW'(1);

   // compare operands: pending scan checks ring entry vs counter; map scan checks the
   // search key; renumber asks whether entry rank is above the removed rank
   always_comb begin
      cmp_key_a = (cmd_ff == CMD_LOOKUP_ID) ? map_rd_id_ff : map_rd_handle_ff;
      cmp_key_b = key_ff;
      cmp_ord_a = map_rd_order_ff;
      cmp_ord_b = best_order_ff;
      if (state_ff == S_PSCAN) begin
         cmp_key_a = pend_rdata_ff;
         cmp_key_b = ctr_ff;
      end
      if (state_ff == S_RENUM) begin
         cmp_ord_a = best_order_ff;
         cmp_ord_b = map_rd_order_ff;
      end
   end

   phm_match_unit #(
      .ORDER_W (MI)
   ) u_match (
      .key_a (cmp_key_a),
      .key_b (cmp_key_b),
      .id_c  (map_rd_id_ff),
      .id_d  (best_id_ff),
      .ord_a (cmp_ord_a),
      .ord_b (cmp_ord_b),
      .res   (mres)
   );

   // lowest id wins, then lowest rank
   always_comb begin
      take_now = valid_ff[midx_ff] && mres.key_eq &&
                 (!best_valid_ff || mres.id_lt || (mres.id_eq && mres.ord_lt));
      nb_valid  = best_valid_ff || take_now;
      nb_id     = take_now ? map_rd_id_ff     : best_id_ff;
      nb_handle = take_now ? map_rd_handle_ff : best_handle_ff;
      nb_order  = take_now ? map_rd_order_ff  : best_order_ff;
      nb_idx    = take_now ? midx_ff          : best_idx_ff;
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      fill_in        = fill_ff;
      ctr_in         = ctr_ff;
      valid_in       = valid_ff;
      used_in        = used_ff;
      cmd_in         = cmd_ff;
      key_in         = key_ff;
      handle_in      = handle_ff;
      scan_ptr_in    = scan_ptr_ff;
      scan_k_in      = scan_k_ff;
      midx_in        = midx_ff;
      best_valid_in  = best_valid_ff;
      best_id_in     = best_id_ff;
      best_handle_in = best_handle_ff;
      best_order_in  = best_order_ff;
      best_idx_in    = best_idx_ff;
      res_id_in      = res_id_ff;
      res_handle_in  = res_handle_ff;
      res_found_in   = res_found_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_id_in      = rsp_id_ff;
      rsp_handle_in  = rsp_handle_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_status_in  = rsp_status_ff;
      pend_we        = 1'b0;
      map_we         = 1'b0;
      map_waddr      = midx_ff;
      map_wid        = map_rd_id_ff;
      map_whandle    = map_rd_handle_ff;
      map_word       = map_rd_order_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               cmd_in        = req_bus.cmd;
               key_in        = (req_bus.cmd == CMD_LOOKUP_ID) ? req_bus.req_id
                                                              : req_bus.handle;
               handle_in     = req_bus.handle;
               res_id_in     = '0;
               res_handle_in = '0;
               res_found_in  = 1'b0;
               res_status_in = ST_OK;
               scan_ptr_in   = head_ff;
               scan_k_in     = '0;
               midx_in       = '0;
               best_valid_in = 1'b0;
               state_in      = S_DONE;
               case (req_bus.cmd)
                  CMD_NEXT_ID: begin
                     if (fill_ff == '0) begin
                        res_id_in = ctr_ff;
                        ctr_in    = ctr_ff + 32'd1;
                     end else begin
                        state_in = S_PSCAN;
                     end
                  end
                  CMD_PUSH: begin
                     if (fill_ff == PEND_FULL) begin
                        res_status_in = ST_PEND_FULL;
                     end else begin
                        pend_we = 1'b1;
                        fill_in = fill_ff + FW'(1);
                     end
                  end
                  CMD_COMPLETE: begin
                     if (fill_ff == '0) begin
                        res_status_in = ST_PEND_EMPTY;
                     end else if (used_ff == MAP_FULL) begin
                        res_status_in = ST_MAP_FULL;
                     end else begin
                        state_in = S_FREE;
                     end
                  end
                  CMD_REMOVE, CMD_LOOKUP_ID, CMD_LOOKUP_HANDLE: begin
                     if (used_ff == '0) begin
                        res_status_in = ST_NOT_FOUND;
                     end else begin
                        state_in = S_MSCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // ring entry for scan_ptr_ff is in pend_rdata_ff
         S_PSCAN: begin
            if (mres.key_eq) begin
               // candidate still pending: skip it and rescan from the head
               ctr_in      = ctr_ff + 32'd1;
               scan_ptr_in = head_ff;
               scan_k_in   = '0;
            end else if (scan_k_ff == fill_ff - FW'(1)) begin
               res_id_in = ctr_ff;
               ctr_in    = ctr_ff + 32'd1;
               state_in  = S_DONE;
            end else begin
               scan_k_in   = scan_k_ff + FW'(1);
               scan_ptr_in = scan_ptr_next;
            end
         end

         // head entry sits in pend_rdata_ff; a free slot is known to exist
         S_FREE: begin
            if (!valid_ff[midx_ff]) begin
               map_we             = 1'b1;
               map_waddr          = midx_ff;
               map_wid            = pend_rdata_ff;
               map_whandle        = handle_ff;
               map_word           = MI'(used_ff);
               valid_in[midx_ff]  = 1'b1;
               used_in            = used_ff + UW'(1);
               head_in            = head_next;
               fill_in            = fill_ff - FW'(1);
               res_id_in          = pend_rdata_ff;
               state_in           = S_DONE;
            end else begin
               midx_in = midx_ff + MI'(1);
            end
         end

         // map entry for midx_ff is in map_rd_*_ff
         S_MSCAN: begin
            best_valid_in  = nb_valid;
            best_id_in     = nb_id;
            best_handle_in = nb_handle;
            best_order_in  = nb_order;
            best_idx_in    = nb_idx;
            if (midx_ff == MAP_LAST) begin
               state_in = S_DONE;
               if (!nb_valid) begin
                  res_status_in = ST_NOT_FOUND;
               end else begin
                  res_found_in = 1'b1;
                  case (cmd_ff)
                     CMD_REMOVE: begin
                        res_id_in        = nb_id;
                        valid_in[nb_idx] = 1'b0;
                        used_in          = used_ff - UW'(1);
                        midx_in          = '0;
                        state_in         = S_RENUM;
                     end
                     CMD_LOOKUP_ID: res_handle_in = nb_handle;
                     default:       res_id_in     = nb_id;
                  endcase
               end
            end else begin
               midx_in = midx_ff + MI'(1);
            end
         end

         // ranks above the removed one move down by one
         S_RENUM: begin
            if (valid_ff[midx_ff] && mres.ord_lt) begin
               map_we      = 1'b1;
               map_waddr   = midx_ff;
               map_wid     = map_rd_id_ff;
               map_whandle = map_rd_handle_ff;
               map_word    = map_rd_order_ff - MI'(1);
            end
            if (midx_ff == MAP_LAST) begin
               state_in = S_DONE;
            end else begin
               midx_in = midx_ff + MI'(1);
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_id_in     = res_id_ff;
               rsp_handle_in = res_handle_ff;
               rsp_found_in  = res_found_ff;
               rsp_count_in  = 5'(fill_ff);
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         ctr_ff       <= '0;
         valid_ff     <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         ctr_ff       <= ctr_in;
         valid_ff     <= valid_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      key_ff         <= key_in;
      handle_ff      <= handle_in;
      scan_ptr_ff    <= scan_ptr_in;
      scan_k_ff      <= scan_k_in;
      midx_ff        <= midx_in;
      best_valid_ff  <= best_valid_in;
      best_id_ff     <= best_id_in;
      best_handle_ff <= best_handle_in;
      best_order_ff  <= best_order_in;
      best_idx_ff    <= best_idx_in;
      res_id_ff      <= res_id_in;
      res_handle_ff  <= res_handle_in;
      res_found_ff   <= res_found_in;
      res_status_ff  <= res_status_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_handle_ff  <= rsp_handle_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_status_ff  <= rsp_status_in;
   end

   // pending ring: one write port, registered read at the next scan pointer
   always_ff @(posedge clock) begin
      if (pend_we) begin
         pend_mem[pend_waddr] <= req_bus.req_id;
      end
      pend_rdata_ff <= pend_mem[scan_ptr_in];
   end

   // map store: one write port, registered read at the next scan index
   always_ff @(posedge clock) begin
      if (map_we) begin
         map_id_mem[map_waddr]     <= map_wid;
         map_handle_mem[map_waddr] <= map_whandle;
         map_order_mem[map_waddr]  <= map_word;
      end
      map_rd_id_ff     <= map_id_mem[midx_in];
      map_rd_handle_ff <= map_handle_mem[midx_in];
      map_rd_order_ff  <= map_order_mem[midx_in];
   end

   // checks
   `PHM_ASSERT_NOW(a_used_matches_valid, clock, reset, 1'b1,
      (used_ff == UW'($countones(valid_ff))), "map count out of step with valid bits")
   `PHM_ASSERT_NOW(a_fill_bounded, clock, reset, 1'b1,
      (fill_ff <= PEND_FULL), "pending fill above depth")
   `PHM_ASSERT_NEXT(a_busy_after_accept, clock, reset, (req_bus.valid && req_bus.ready),
      (!req_bus.ready), "request taken while previous one in flight")
   `PHM_ASSERT_NOW(a_load_from_done, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff == S_DONE), "response raised outside the done state")

endmodule

`default_nettype wire
